### hdl/jump_point_row_scanner_macros.svh
// Assertion macros shared by the jump-point row scanner RTL files.
// Depends on nothing; the using module must have i_clk and i_rst_n.
`ifndef JUMP_POINT_ROW_SCANNER_MACROS_SVH
`define JUMP_POINT_ROW_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define JPRS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("jump_point_row_scanner: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define JPRS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("jump_point_row_scanner: next-cycle check failed");
`else
`define JPRS_ASSERT_IMP(label, ante, cons)
`define JPRS_ASSERT_NXT(label, ante, cons)
`endif
`endif

### hdl/jprs_pkg.sv
// Package for the jump-point row scanner: widths, register indexes and payload types.
// Depends on nothing; used by jprs_core and jump_point_row_scanner.
package jprs_pkg;

    localparam int NAV_W         = 16;   // navcell word width
    localparam int POS_W         = 10;   // column position width
    localparam int RW_W          = 11;   // row width register width
    localparam int MAX_ROW_WIDTH = 1024; // widest row the cache holds
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PASS_CLASS_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_DIAG_GAPS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH       = 2'd2;

    localparam logic [RW_W-1:0] ROW_WIDTH_RESET = 11'd1024;

    typedef struct packed {
        logic [NAV_W-1:0] cell_here;
        logic [NAV_W-1:0] cell_above;
        logic [NAV_W-1:0] cell_below;
        logic             row_start;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] next_pos;
        logic             next_is_obstruction;
        logic             next_known;
        logic [POS_W:0]   cache_word;
    } t_out_item;

    // Passability of one column after masking, plus the row start flag.
    typedef struct packed {
        logic here_pass;
        logic above_pass;
        logic below_pass;
        logic row_start;
    } t_pass_item;

    // Configuration seen by the scan core.
    typedef struct packed {
        logic            allow_diagonal_gaps;
        logic [RW_W-1:0] row_width;
    } t_scan_cfg;

    // Running answer carried from one column to the next.
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             obstruction;
        logic             known;
    } t_answer;

endpackage

### hdl/jprs_core.sv
// Scan core of the jump-point row scanner: column delay, position counter and running answer.
// Depends on jprs_pkg and jump_point_row_scanner_macros.svh.
`include "jump_point_row_scanner_macros.svh"

module jprs_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  jprs_pkg::t_pass_item  i_cell,
    input  jprs_pkg::t_scan_cfg   i_cfg,
    output jprs_pkg::t_out_item   o_result
);
    import jprs_pkg::*;

    logic             r_prev_here;
    logic             r_prev_above;
    logic             r_prev_below;
    logic             r_older_above;
    logic             r_older_below;
    t_answer          r_run;
    logic [POS_W-1:0] r_col_pos;

    logic [RW_W-1:0]  w_width;
    logic [RW_W-1:0]  w_width_m1;
    logic [POS_W-1:0] w_start_pos;
    logic             w_c_here;
    logic             w_c_above;
    logic             w_c_below;
    logic             w_o_above;
    logic             w_o_below;
    logic [POS_W-1:0] w_pos;
    logic [POS_W-1:0] w_cand;
    logic             w_jump;
    t_answer          n_run;

    // Clamp the row width into 1 .. MAX_ROW_WIDTH and take its last position.
    always_comb begin
        if (i_cfg.row_width == '0) begin
            w_width = RW_W'(1);
        end else if (i_cfg.row_width > RW_W'(MAX_ROW_WIDTH)) begin
            w_width = RW_W'(MAX_ROW_WIDTH);
        end else begin
            w_width = i_cfg.row_width;
        end
        w_width_m1  = w_width - RW_W'(1);
        w_start_pos = w_width_m1[POS_W-1:0];
    end

    always_comb begin
        // A new row sees blocked cells beyond its end.
        if (i_cell.row_start) begin
            w_c_here  = 1'b0;
            w_c_above = 1'b0;
            w_c_below = 1'b0;
            w_o_above = 1'b0;
            w_o_below = 1'b0;
            w_pos     = w_start_pos;
        end else begin
            w_c_here  = r_prev_here;
            w_c_above = r_prev_above;
            w_c_below = r_prev_below;
            w_o_above = r_older_above;
            w_o_below = r_older_below;
            w_pos     = r_col_pos - POS_W'(1);
        end
        w_cand = w_pos + POS_W'(1);

        if (i_cfg.allow_diagonal_gaps) begin
            w_jump = (!w_c_above && w_o_above) || (!w_c_below && w_o_below);
        end else begin
            w_jump = (!i_cell.above_pass && w_c_above) || (!i_cell.below_pass && w_c_below);
        end

        if (!w_c_here) begin
            n_run.pos         = w_cand;
            n_run.obstruction = 1'b1;
            n_run.known       = !i_cell.row_start;
        end else if (w_jump) begin
            n_run.pos         = w_cand;
            n_run.obstruction = 1'b0;
            n_run.known       = 1'b1;
        end else begin
            n_run = r_run;
        end
        // An unknown answer always reads as an obstruction at position zero.
        if (!n_run.known) begin
            n_run.pos         = '0;
            n_run.obstruction = 1'b1;
        end

        o_result.next_pos            = n_run.pos;
        o_result.next_is_obstruction = n_run.obstruction;
        o_result.next_known          = n_run.known;
        o_result.cache_word          = {n_run.pos, n_run.obstruction};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_here       <= 1'b0;
            r_prev_above      <= 1'b0;
            r_prev_below      <= 1'b0;
            r_older_above     <= 1'b0;
            r_older_below     <= 1'b0;
            r_run.pos         <= '0;
            r_run.obstruction <= 1'b1;
            r_run.known       <= 1'b0;
            r_col_pos         <= '0;
        end else if (i_step) begin
            r_prev_here   <= i_cell.here_pass;
            r_prev_above  <= i_cell.above_pass;
            r_prev_below  <= i_cell.below_pass;
            r_older_above <= w_c_above;
            r_older_below <= w_c_below;
            r_run         <= n_run;
            r_col_pos     <= w_pos;
        end
    end

    `JPRS_ASSERT_NXT(a_start_pos, i_step && i_cell.row_start, r_col_pos == $past(w_start_pos))
    `JPRS_ASSERT_NXT(a_count_down, i_step && !i_cell.row_start, r_col_pos == POS_W'($past(r_col_pos) - POS_W'(1)))
    `JPRS_ASSERT_NXT(a_start_unknown, i_step && i_cell.row_start, !r_run.known && r_run.obstruction)
    `JPRS_ASSERT_NXT(a_hold_idle, !i_step, $stable(r_run) && $stable(r_col_pos))

endmodule

### hdl/jump_point_row_scanner.sv
// Jump-point row scanner, one scan direction of a jump-point cache for a grid pathfinder.
// The block takes one column per transaction from the last position of a row back to
// position 0, each with the navcell words of the cell and its neighbours above and below,
// and returns for that cell the nearest later obstruction point or forced-neighbour jump
// point. One transaction is accepted every clock cycle when the result side keeps up. The
// input register captures the masked passability bits at the accepting edge, and the
// result register is loaded from it when the result register can take a new value. When the
// result is not taken, the result register holds, and a full input register holds and the
// input side stalls for as long as the result waits. The rate is set by the registered
// feedback of the running answer and the column delay held in jprs_core. Configuration is
// written through a plain write port (index 0 class mask, 1 diagonal-gap rule, 2 row
// width) and must only be changed while no transaction is in flight. Cells past the row
// end count as blocked; feed row_start on the first column of every row.
// Depends on jprs_pkg, jprs_core and jump_point_row_scanner_macros.svh.
`include "jump_point_row_scanner_macros.svh"

module jump_point_row_scanner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [jprs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [jprs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // Column input channel.
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  jprs_pkg::t_in_item                  i_in_item,
    // Result channel.
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output jprs_pkg::t_out_item                 o_out_item
);
    import jprs_pkg::*;

    // Configuration registers.
    logic [NAV_W-1:0] r_pass_class_mask;
    logic             r_allow_diag_gaps;
    logic [RW_W-1:0]  r_row_width;

    // Input stage and result stage.
    logic       r_s1_valid;
    t_pass_item r_s1_item;
    t_pass_item n_s1_item;
    logic       r_out_valid;
    t_out_item  r_out_item;

    logic       w_s2_take;
    logic       w_step;
    logic       w_mask_we;
    t_scan_cfg  w_scan_cfg;
    t_out_item  w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_class_mask <= '0;
            r_allow_diag_gaps <= 1'b0;
            r_row_width       <= ROW_WIDTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PASS_CLASS_MASK: begin
                    r_pass_class_mask <= i_cfg_wdata[NAV_W-1:0];
                end
                CFG_ALLOW_DIAG_GAPS: begin
                    r_allow_diag_gaps <= i_cfg_wdata[0];
                end
                CFG_ROW_WIDTH: begin
                    r_row_width <= i_cfg_wdata[RW_W-1:0];
                end
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // The result register can take a new value when it is empty or being drained;
    // the input register can take a new transaction when it is empty or moving on.
    assign w_s2_take  = !r_out_valid || i_out_ready;
    assign w_step     = r_s1_valid && w_s2_take;
    assign o_in_ready = !r_s1_valid || w_s2_take;

    // Reduce each navcell word to a passability bit before registering it.
    always_comb begin
        n_s1_item.here_pass  = (i_in_item.cell_here & r_pass_class_mask) == '0;
        n_s1_item.above_pass = (i_in_item.cell_above & r_pass_class_mask) == '0;
        n_s1_item.below_pass = (i_in_item.cell_below & r_pass_class_mask) == '0;
        n_s1_item.row_start  = i_in_item.row_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_item <= n_s1_item;
        end
    end

    assign w_scan_cfg.allow_diagonal_gaps = r_allow_diag_gaps;
    assign w_scan_cfg.row_width           = r_row_width;

    jprs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_cell   (r_s1_item),
        .i_cfg    (w_scan_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_take) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_mask_we = i_cfg_we && (i_cfg_index == CFG_PASS_CLASS_MASK);

    `JPRS_ASSERT_NXT(a_s1_kept, r_s1_valid && !w_s2_take, r_s1_valid)
    `JPRS_ASSERT_NXT(a_step_to_out, w_step, r_out_valid)
    `JPRS_ASSERT_NXT(a_mask_write, w_mask_we, r_pass_class_mask == $past(i_cfg_wdata))

endmodule
